// ===== rtl/nrfp_pkg.sv =====
package nrfp_pkg;

    localparam int unsigned NUM_PAGES        = 224;
    localparam int unsigned PAPER_START_LINE = 63;

    localparam logic [7:0] ID_VALUE      = 8'd10;
    localparam logic [7:0] VERSION_VALUE = 8'h32;
    localparam logic [7:0] ROM_PAGE      = 8'hFF;

    localparam logic [7:0] REG_ID       = 8'h00;
    localparam logic [7:0] REG_VERSION  = 8'h01;
    localparam logic [7:0] REG_SPEED    = 8'h07;
    localparam logic [7:0] REG_PERIPH3  = 8'h08;
    localparam logic [7:0] REG_SUBVER   = 8'h0E;
    localparam logic [7:0] REG_L2_BANK  = 8'h12;
    localparam logic [7:0] REG_L2_SHBNK = 8'h13;
    localparam logic [7:0] REG_TRANS    = 8'h14;
    localparam logic [7:0] REG_LINE_HI  = 8'h1E;
    localparam logic [7:0] REG_LINE_LO  = 8'h1F;
    localparam logic [7:0] REG_IRQ_CTRL = 8'h22;
    localparam logic [7:0] REG_IRQ_LINE = 8'h23;
    localparam logic [7:0] REG_SPR_TR   = 8'h4A;
    localparam logic [7:0] REG_ULA_TR   = 8'h4B;
    localparam logic [7:0] REG_TM_TR    = 8'h4C;
    localparam logic [7:0] REG_MMU0     = 8'h50;
    localparam logic [7:0] REG_MMU7     = 8'h57;

    localparam logic [1:0] CFG_TPL   = 2'd0;
    localparam logic [1:0] CFG_FRAME = 2'd1;

    typedef enum logic [2:0] {
        ACT_REG_WR,
        ACT_REG_RD,
        ACT_PORT_MAIN,
        ACT_PORT_HIGH,
        ACT_PORT_SPECIAL,
        ACT_PORT_L2,
        ACT_SOFT_RST,
        ACT_HARD_RST
    } action_t;

    function automatic logic [7:0] slot_default(input logic [2:0] s);
        logic [7:0] p;
        unique case (s)
            3'd0, 3'd1: p = ROM_PAGE;
            3'd2:       p = 8'd10;
            3'd3:       p = 8'd11;
            3'd4:       p = 8'd4;
            3'd5:       p = 8'd5;
            3'd6:       p = 8'd0;
            default:    p = 8'd1;
        endcase
        return p;
    endfunction

    function automatic logic is_listed(input logic [7:0] r);
        return (r == REG_SPEED) || (r == REG_TRANS) || (r == REG_SPR_TR) ||
               (r == REG_ULA_TR) || (r == REG_TM_TR) ||
               ((r >= REG_MMU0) && (r <= REG_MMU7));
    endfunction

    function automatic logic [7:0] reg_default(input logic [7:0] r);
        logic [7:0] v;
        v = 8'h00;
        if (r == REG_TRANS || r == REG_ULA_TR) v = 8'hE3;
        else if (r == REG_TM_TR) v = 8'h0F;
        else if (r >= REG_MMU0 && r <= REG_MMU7) v = slot_default(r[2:0]);
        return v;
    endfunction

    function automatic logic [2:0] allram_bank(input logic [1:0] map, input logic [1:0] q);
        logic [2:0] b;
        unique case ({map, q})
            4'h0: b = 3'd0; 4'h1: b = 3'd1; 4'h2: b = 3'd2; 4'h3: b = 3'd3;
            4'h4: b = 3'd4; 4'h5: b = 3'd5; 4'h6: b = 3'd6; 4'h7: b = 3'd7;
            4'h8: b = 3'd4; 4'h9: b = 3'd5; 4'hA: b = 3'd6; 4'hB: b = 3'd3;
            4'hC: b = 3'd4; 4'hD: b = 3'd7; 4'hE: b = 3'd6;
            default: b = 3'd3;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/next_register_file_and_paging_core.sv =====
// Raster line reads run up to four 20-step divisions in the serial divider. One
// request is worked on at a time; the last result is held in the output register
// while the next request is accepted.
// Reset: synchronous, active low; register store defaults come from per-entry
// valid bits, so no clearing pass is needed.
module next_register_file_and_paging_core import nrfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [7:0]  s_reg_index,
    input  logic [7:0]  s_data,
    input  logic [19:0] s_cpu_tstates,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_read_data,
    output logic [2:0]  m_mmu_slot,
    output logic [7:0]  m_mmu_page,
    output logic        m_last,
    output logic        m_line_irq_enabled,
    output logic        m_ula_irq_disabled,
    output logic [8:0]  m_line_irq_line,
    output logic        m_layer2_write_active,
    output logic [7:0]  m_layer2_page,
    output logic        m_video_shadow,
    output logic        m_rom_select,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DIV, S_GEN, S_COMMIT, S_EMIT
    } state_t;

    state_t      state_reg;
    action_t     act_reg;
    logic [7:0]  idx_reg;
    logic [7:0]  dat_reg;
    logic [19:0] ts_reg;

    logic [9:0]  tpl_reg;
    logic [17:0] frame_reg;

    logic [7:0]  slot_pages_reg [8];
    logic [7:0]  main_reg;
    logic [3:0]  high_reg;
    logic [7:0]  special_reg;
    logic [7:0]  l2_reg;
    logic [8:0]  irq_line_reg;
    logic [1:0]  irq_flags_reg;
    logic [2:0]  latches_reg;
    logic        rom_in_use_reg;
    logic [1:0]  speed_reg;
    logic        r08_b6_reg;
    logic [7:0]  r12_reg;
    logic [7:0]  r13_reg;
    logic [255:0] vld_reg;
    logic        hit_reg;

    logic [2:0]  k_reg;
    logic [3:0]  cnt_reg;
    logic [2:0]  ei_reg;
    logic [2:0]  pend_slot_reg [8];
    logic [7:0]  pend_page_reg [8];
    logic [7:0]  rd_reg;

    logic [1:0]  phase_reg;
    logic        div_start_reg;
    logic [19:0] div_a_reg;
    logic [17:0] div_b_reg;
    logic [17:0] lines_reg;
    logic [17:0] line_reg;

    logic        div_done;
    logic [19:0] div_q;
    logic [17:0] div_r;
    logic [7:0]  mem_rdata;
    logic        mem_we;

    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [7:0]  m_read_data_reg;
    logic [2:0]  m_slot_reg;
    logic [7:0]  m_page_reg;
    logic        m_last_reg;
    logic        m_lie_reg;
    logic        m_uid_reg;
    logic [8:0]  m_line_reg;
    logic        m_l2a_reg;
    logic [7:0]  m_l2p_reg;
    logic        m_vs_reg;
    logic        m_rom_reg;

    logic        c_vld;
    logic [2:0]  c_slot;
    logic [7:0]  c_page;
    logic [6:0]  bank;
    logic        bank_ok;
    logic        main_ignored;
    logic [7:0]  l2_bank;
    logic [9:0]  l2_pg;
    logic        l2_act;
    logic [17:0] raster;
    logic        load;
    logic        is_last;

    nrfp_ram #(.WIDTH(8), .DEPTH(256)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (dat_reg),
        .raddr ((state_reg == S_IDLE) ? s_reg_index : idx_reg),
        .rdata (mem_rdata)
    );

    nrfp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign mem_we       = (state_reg == S_COMMIT) && (act_reg == ACT_REG_WR);
    assign main_ignored = latches_reg[0] && !r08_b6_reg;
    assign bank = {(act_reg == ACT_PORT_HIGH) ? dat_reg[3:0] : high_reg,
                   (act_reg == ACT_PORT_MAIN) ? dat_reg[2:0] : main_reg[2:0]};
    assign bank_ok = {1'b0, bank} < 8'(NUM_PAGES / 2);

    always_comb begin
        c_vld  = 1'b0;
        c_slot = k_reg;
        c_page = '0;
        unique case (act_reg)
            ACT_REG_WR: begin
                c_vld  = (k_reg == 3'd0) && (idx_reg >= REG_MMU0) && (idx_reg <= REG_MMU7);
                c_slot = idx_reg[2:0];
                c_page = dat_reg;
            end
            ACT_PORT_MAIN: begin
                if (k_reg[2:1] == 2'b00) begin
                    c_vld  = !main_ignored && bank_ok;
                    c_slot = {2'b11, k_reg[0]};
                    c_page = {bank, k_reg[0]};
                end else if (k_reg[2:1] == 2'b01) begin
                    c_vld  = !main_ignored && !special_reg[0] &&
                             (slot_pages_reg[{2'b00, k_reg[0]}] == ROM_PAGE);
                    c_slot = {2'b00, k_reg[0]};
                    c_page = ROM_PAGE;
                end
            end
            ACT_PORT_HIGH: begin
                c_vld  = (k_reg[2:1] == 2'b00) && bank_ok;
                c_slot = {2'b11, k_reg[0]};
                c_page = {bank, k_reg[0]};
            end
            ACT_PORT_SPECIAL: begin
                if (dat_reg[0]) begin
                    c_vld  = 1'b1;
                    c_page = {4'b0000, allram_bank(dat_reg[2:1], k_reg[2:1]), k_reg[0]};
                end else if (k_reg[2:1] == 2'b00) begin
                    c_vld  = slot_pages_reg[k_reg] == ROM_PAGE;
                    c_page = ROM_PAGE;
                end else if (k_reg[2:1] == 2'b11) begin
                    c_vld  = bank_ok;
                    c_page = {bank, k_reg[0]};
                end else begin
                    c_vld  = 1'b1;
                    c_page = slot_default(k_reg);
                end
            end
            default: c_vld = 1'b0;
        endcase
    end

    assign l2_bank = l2_reg[3] ? r13_reg : r12_reg;
    assign l2_pg   = {({1'b0, l2_bank} + {7'b0, l2_reg[7:6]}), 1'b0};
    assign l2_act  = l2_reg[0] && ((l2_pg + 10'd1) < 10'(NUM_PAGES));
    assign raster  = (line_reg >= div_r) ? (line_reg - div_r) : (line_reg + lines_reg - div_r);
    assign load    = !m_valid_reg || m_ready;
    assign is_last = (cnt_reg == 4'd0) || ({1'b0, ei_reg} == (cnt_reg - 4'd1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tpl_reg        <= 10'd228;
            frame_reg      <= 18'd70908;
            main_reg       <= '0;
            high_reg       <= '0;
            special_reg    <= '0;
            l2_reg         <= '0;
            irq_line_reg   <= '0;
            irq_flags_reg  <= '0;
            latches_reg    <= '0;
            rom_in_use_reg <= 1'b0;
            speed_reg      <= '0;
            r08_b6_reg     <= 1'b0;
            r12_reg        <= '0;
            r13_reg        <= '0;
            vld_reg        <= '0;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                slot_pages_reg[i] <= slot_default(3'(i));
            end
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_valid) begin
                if (cfg_index == CFG_TPL) tpl_reg <= cfg_data[9:0];
                else if (cfg_index == CFG_FRAME) frame_reg <= cfg_data;
            end
            if (m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg <= action_t'(s_action);
                        idx_reg <= s_reg_index;
                        dat_reg <= s_data;
                        ts_reg  <= s_cpu_tstates;
                        hit_reg <= vld_reg[s_reg_index];
                        rd_reg  <= '0;
                        k_reg   <= '0;
                        cnt_reg <= '0;
                        state_reg <= (action_t'(s_action) == ACT_REG_RD) ? S_READ : S_GEN;
                    end
                end
                S_READ: begin
                    state_reg <= S_COMMIT;
                    if (idx_reg == REG_ID) rd_reg <= ID_VALUE;
                    else if (idx_reg == REG_VERSION) rd_reg <= VERSION_VALUE;
                    else if (idx_reg == REG_SUBVER) rd_reg <= 8'h00;
                    else if (idx_reg == REG_SPEED) rd_reg <= {2'b00, speed_reg, 2'b00, speed_reg};
                    else if (idx_reg == REG_LINE_HI || idx_reg == REG_LINE_LO) begin
                        if (tpl_reg != '0) begin
                            div_start_reg <= 1'b1;
                            div_a_reg     <= {2'b00, frame_reg};
                            div_b_reg     <= {8'b0, tpl_reg};
                            phase_reg     <= 2'd0;
                            state_reg     <= S_DIV;
                        end
                    end
                    else if (idx_reg >= REG_MMU0 && idx_reg <= REG_MMU7)
                        rd_reg <= slot_pages_reg[idx_reg[2:0]];
                    else rd_reg <= hit_reg ? mem_rdata : reg_default(idx_reg);
                end
                S_DIV: begin
                    if (div_done) begin
                        unique case (phase_reg)
                            2'd0: begin
                                lines_reg <= div_q[17:0];
                                if (div_q == '0) state_reg <= S_COMMIT;
                                else begin
                                    div_start_reg <= 1'b1;
                                    div_a_reg     <= ts_reg >> speed_reg;
                                    phase_reg     <= 2'd1;
                                end
                            end
                            2'd1: begin
                                div_start_reg <= 1'b1;
                                div_a_reg     <= div_q;
                                div_b_reg     <= lines_reg;
                                phase_reg     <= 2'd2;
                            end
                            2'd2: begin
                                line_reg      <= div_r;
                                div_start_reg <= 1'b1;
                                div_a_reg     <= 20'(PAPER_START_LINE);
                                phase_reg     <= 2'd3;
                            end
                            default: begin
                                rd_reg    <= (idx_reg == REG_LINE_HI) ? {7'b0, raster[8]}
                                                                      : raster[7:0];
                                state_reg <= S_COMMIT;
                            end
                        endcase
                    end
                end
                S_GEN: begin
                    if (c_vld) begin
                        pend_slot_reg[cnt_reg[2:0]] <= c_slot;
                        pend_page_reg[cnt_reg[2:0]] <= c_page;
                        cnt_reg <= cnt_reg + 4'd1;
                        slot_pages_reg[c_slot] <= c_page;
                    end
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd7) state_reg <= S_COMMIT;
                end
                S_COMMIT: begin
                    ei_reg    <= '0;
                    state_reg <= S_EMIT;
                    unique case (act_reg)
                        ACT_REG_WR: begin
                            vld_reg[idx_reg] <= 1'b1;
                            if (idx_reg == REG_IRQ_CTRL) begin
                                irq_flags_reg   <= dat_reg[2:1];
                                irq_line_reg[8] <= dat_reg[0];
                            end
                            if (idx_reg == REG_IRQ_LINE) irq_line_reg[7:0] <= dat_reg;
                            if (idx_reg == REG_SPEED) speed_reg <= dat_reg[1:0];
                            if (idx_reg == REG_PERIPH3) r08_b6_reg <= dat_reg[6];
                            if (idx_reg == REG_L2_BANK) r12_reg <= dat_reg;
                            if (idx_reg == REG_L2_SHBNK) r13_reg <= dat_reg;
                        end
                        ACT_PORT_MAIN: begin
                            if (!main_ignored) begin
                                main_reg    <= dat_reg;
                                latches_reg <= {dat_reg[3], dat_reg[4],
                                                latches_reg[0] | dat_reg[5]};
                                if (!special_reg[0]) rom_in_use_reg <= dat_reg[4];
                            end
                        end
                        ACT_PORT_HIGH: high_reg <= dat_reg[3:0];
                        ACT_PORT_SPECIAL: begin
                            special_reg <= dat_reg;
                            if (!dat_reg[0]) rom_in_use_reg <= latches_reg[1];
                        end
                        ACT_PORT_L2: l2_reg <= dat_reg;
                        ACT_SOFT_RST, ACT_HARD_RST: begin
                            main_reg       <= '0;
                            high_reg       <= '0;
                            special_reg    <= '0;
                            l2_reg         <= '0;
                            irq_line_reg   <= '0;
                            irq_flags_reg  <= '0;
                            latches_reg    <= '0;
                            rom_in_use_reg <= 1'b0;
                            speed_reg      <= '0;
                            for (int i = 0; i < 8; i++) begin
                                slot_pages_reg[i] <= slot_default(3'(i));
                            end
                            if (act_reg == ACT_HARD_RST) begin
                                vld_reg    <= '0;
                                r08_b6_reg <= 1'b0;
                                r12_reg    <= '0;
                                r13_reg    <= '0;
                            end else begin
                                for (int i = 0; i < 256; i++) begin
                                    if (is_listed(8'(i))) vld_reg[i] <= 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_EMIT: begin
                    if (load) begin
                        m_valid_reg     <= 1'b1;
                        m_kind_reg      <= cnt_reg != '0;
                        m_read_data_reg <= (cnt_reg != '0) ? 8'h00 : rd_reg;
                        m_slot_reg      <= (cnt_reg != '0) ? pend_slot_reg[ei_reg] : 3'd0;
                        m_page_reg      <= (cnt_reg != '0) ? pend_page_reg[ei_reg] : 8'h00;
                        m_last_reg      <= is_last;
                        m_lie_reg       <= irq_flags_reg[0];
                        m_uid_reg       <= irq_flags_reg[1];
                        m_line_reg      <= irq_line_reg;
                        m_l2a_reg       <= l2_act;
                        m_l2p_reg       <= l2_act ? l2_pg[7:0] : 8'h00;
                        m_vs_reg        <= latches_reg[2];
                        m_rom_reg       <= rom_in_use_reg;
                        ei_reg          <= ei_reg + 3'd1;
                        if (is_last) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready               = state_reg == S_IDLE;
    assign cfg_ready             = 1'b1;
    assign m_valid               = m_valid_reg;
    assign m_kind                = m_kind_reg;
    assign m_read_data           = m_read_data_reg;
    assign m_mmu_slot            = m_slot_reg;
    assign m_mmu_page            = m_page_reg;
    assign m_last                = m_last_reg;
    assign m_line_irq_enabled    = m_lie_reg;
    assign m_ula_irq_disabled    = m_uid_reg;
    assign m_line_irq_line       = m_line_reg;
    assign m_layer2_write_active = m_l2a_reg;
    assign m_layer2_page         = m_l2p_reg;
    assign m_video_shadow        = m_vs_reg;
    assign m_rom_select          = m_rom_reg;

endmodule

// ===== rtl/nrfp_ram.sv =====
module nrfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/nrfp_div.sv =====
module nrfp_div import nrfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [19:0] dividend,
    input  logic [17:0] divisor,
    output logic        done,
    output logic [19:0] quotient,
    output logic [17:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [19:0] q_reg;
    logic [17:0] r_reg;
    logic [17:0] d_reg;
    logic [18:0] shifted;
    logic [19:0] trial;

    assign shifted = {r_reg, q_reg[19]};
    assign trial   = {1'b0, shifted} - {2'b00, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                if (!trial[19]) begin
                    r_reg <= trial[17:0];
                    q_reg <= {q_reg[18:0], 1'b1};
                end else begin
                    r_reg <= shifted[17:0];
                    q_reg <= {q_reg[18:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd19) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== rtl/nrfp_checker.sv =====
module nrfp_checker import nrfp_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_kind,
    input logic [7:0] m_read_data,
    input logic [2:0] m_mmu_slot,
    input logic [7:0] m_mmu_page,
    input logic       m_last,
    input logic       m_layer2_write_active,
    input logic [7:0] m_layer2_page
);

    a_ack_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_last)
        else $error("acknowledge not marked last");

    a_ack_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_mmu_slot == 3'd0 && m_mmu_page == 8'h00)
        else $error("acknowledge carries slot data");

    a_slot_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_read_data == 8'h00)
        else $error("slot update carries read data");

    a_l2_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_layer2_write_active |-> m_layer2_page == 8'h00)
        else $error("inactive layer-2 page not zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mmu_page) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind next_register_file_and_paging_core nrfp_checker u_nrfp_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_kind                (m_kind),
    .m_read_data           (m_read_data),
    .m_mmu_slot            (m_mmu_slot),
    .m_mmu_page            (m_mmu_page),
    .m_last                (m_last),
    .m_layer2_write_active (m_layer2_write_active),
    .m_layer2_page         (m_layer2_page)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import nrfp_pkg::*;

    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  reg_index;
        logic [7:0]  data;
        logic [19:0] tstates;
    } request_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] read_data;
        logic [2:0] slot;
        logic [7:0] page;
        logic       last;
        logic       line_en;
        logic       ula_dis;
        logic [8:0] line;
        logic       l2_active;
        logic [7:0] l2_page;
        logic       shadow;
        logic       rom;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_action;
    logic [7:0]  s_reg_index;
    logic [7:0]  s_data;
    logic [19:0] s_cpu_tstates;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [7:0]  m_read_data;
    logic [2:0]  m_mmu_slot;
    logic [7:0]  m_mmu_page;
    logic        m_last;
    logic        m_line_irq_enabled;
    logic        m_ula_irq_disabled;
    logic [8:0]  m_line_irq_line;
    logic        m_layer2_write_active;
    logic [7:0]  m_layer2_page;
    logic        m_video_shadow;
    logic        m_rom_select;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;

    next_register_file_and_paging_core dut (.*);

    // predictor state
    logic [9:0]  tpl;
    logic [17:0] frame_len;
    logic [7:0]  regs [256];
    logic [7:0]  slots [8];
    logic [7:0]  main_port;
    logic [3:0]  high_bank;
    logic [7:0]  special_port;
    logic [7:0]  l2_port;
    logic [8:0]  irq_line;
    logic [1:0]  irq_flags;
    logic [2:0]  latches;
    logic        rom_in_use;
    outcome_t    slot_news [$];

    request_t    pending [$];
    outcome_t    expected [$];
    int          failures = 0;
    int          cycles = 0;
    int          hold_off = 0;
    bit          long_hold_req = 0;
    int          gap = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic set_slot(input logic [2:0] s, input logic [7:0] p);
        outcome_t o;
        slots[s] = p;
        o = '0;
        o.kind = 1'b1;
        o.slot = s;
        o.page = p;
        slot_news.push_back(o);
    endtask

    task automatic rom_apply();
        rom_in_use = latches[1];
        if (slots[0] == ROM_PAGE) set_slot(3'd0, ROM_PAGE);
        if (slots[1] == ROM_PAGE) set_slot(3'd1, ROM_PAGE);
    endtask

    task automatic top_bank_apply();
        int bank;
        bank = {high_bank, main_port[2:0]};
        if (bank < NUM_PAGES / 2) begin
            set_slot(3'd6, 8'(bank * 2));
            set_slot(3'd7, 8'(bank * 2 + 1));
        end
    endtask

    task automatic restore_defaults(input bit hard);
        if (hard) foreach (regs[i]) regs[i] = 8'h00;
        main_port = 0; high_bank = 0; special_port = 0; l2_port = 0;
        irq_line = 0; irq_flags = 0; latches = 0; rom_in_use = 0;
        for (int i = 0; i < 8; i++) begin
            slots[i] = slot_default(3'(i));
            regs[REG_MMU0 + i] = slot_default(3'(i));
        end
        regs[REG_SPEED] = 8'h00;
        regs[REG_TRANS] = 8'hE3;
        regs[REG_SPR_TR] = 8'h00;
        regs[REG_ULA_TR] = 8'hE3;
        regs[REG_TM_TR] = 8'h0F;
    endtask

    function automatic int unsigned raster(input logic [19:0] ts);
        int unsigned lines, ln, ps;
        if (tpl == 0) return 0;
        lines = frame_len / tpl;
        if (lines == 0) return 0;
        ln = ((ts >> regs[REG_SPEED][1:0]) / tpl) % lines;
        ps = PAPER_START_LINE % lines;
        return (ln + lines - ps) % lines;
    endfunction

    task automatic predict_request(input request_t rq);
        logic [7:0] rd, v;
        logic [1:0] m;
        int unsigned bank, pg;
        outcome_t base;
        int n;
        rd = 0;
        v = rq.data;
        slot_news.delete();
        case (action_t'(rq.action))
            ACT_REG_WR: begin
                regs[rq.reg_index] = v;
                if (rq.reg_index == REG_IRQ_CTRL) begin
                    irq_flags = {v[2], v[1]};
                    irq_line[8] = v[0];
                end else if (rq.reg_index == REG_IRQ_LINE) begin
                    irq_line[7:0] = v;
                end else if (rq.reg_index >= REG_MMU0 && rq.reg_index <= REG_MMU7) begin
                    set_slot(rq.reg_index[2:0], v);
                end
            end
            ACT_REG_RD: begin
                m = regs[REG_SPEED][1:0];
                if (rq.reg_index == REG_ID) rd = ID_VALUE;
                else if (rq.reg_index == REG_VERSION) rd = VERSION_VALUE;
                else if (rq.reg_index == REG_SUBVER) rd = 8'h00;
                else if (rq.reg_index == REG_SPEED) rd = {2'b00, m, 2'b00, m};
                else if (rq.reg_index == REG_LINE_HI) rd = 8'(raster(rq.tstates) >> 8) & 8'h01;
                else if (rq.reg_index == REG_LINE_LO) rd = 8'(raster(rq.tstates));
                else if (rq.reg_index >= REG_MMU0 && rq.reg_index <= REG_MMU7)
                    rd = slots[rq.reg_index[2:0]];
                else rd = regs[rq.reg_index];
            end
            ACT_PORT_MAIN: begin
                if (!(latches[0] && !regs[REG_PERIPH3][6])) begin
                    main_port = v;
                    top_bank_apply();
                    latches = {v[3], v[4], latches[0]};
                    if (!special_port[0]) rom_apply();
                    if (v[5]) latches[0] = 1'b1;
                end
            end
            ACT_PORT_HIGH: begin
                high_bank = v[3:0];
                top_bank_apply();
            end
            ACT_PORT_SPECIAL: begin
                special_port = v;
                if (v[0]) begin
                    for (int s = 0; s < 4; s++) begin
                        pg = allram_bank(v[2:1], 2'(s));
                        set_slot(3'(s * 2), 8'(pg * 2));
                        set_slot(3'(s * 2 + 1), 8'(pg * 2 + 1));
                    end
                end else begin
                    rom_apply();
                    set_slot(3'd2, 8'd10); set_slot(3'd3, 8'd11);
                    set_slot(3'd4, 8'd4);  set_slot(3'd5, 8'd5);
                    top_bank_apply();
                end
            end
            ACT_PORT_L2: l2_port = v;
            ACT_SOFT_RST: restore_defaults(0);
            default: restore_defaults(1);
        endcase
        base = '0;
        if (l2_port[0]) begin
            bank = l2_port[3] ? regs[REG_L2_SHBNK] : regs[REG_L2_BANK];
            pg = (bank + l2_port[7:6]) * 2;
            if (pg + 1 < NUM_PAGES) begin
                base.l2_active = 1;
                base.l2_page = 8'(pg);
            end
        end
        base.line_en = irq_flags[0];
        base.ula_dis = irq_flags[1];
        base.line = irq_line;
        base.shadow = latches[2];
        base.rom = rom_in_use;
        n = slot_news.size();
        if (n == 0) begin
            base.read_data = rd;
            base.last = 1;
            expected.push_back(base);
        end else begin
            for (int k = 0; k < n; k++) begin
                base.kind = 1;
                base.slot = slot_news[k].slot;
                base.page = slot_news[k].page;
                base.last = (k == n - 1);
                expected.push_back(base);
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (s_valid && !s_ready) begin
        end else if (gap > 0) begin
            gap <= gap - 1;
            s_valid <= 0;
        end else if (pending.size() > 0) begin
            request_t rq;
            rq = pending.pop_front();
            predict_request(rq);
            s_valid <= 1;
            s_action <= rq.action;
            s_reg_index <= rq.reg_index;
            s_data <= rq.data;
            s_cpu_tstates <= rq.tstates;
            gap <= rand_gap();
        end else begin
            s_valid <= 0;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        failures++;
    endtask

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    outcome_t e;
                    e = expected.pop_front();
                    if (m_kind !== e.kind) report_mismatch("kind", m_kind, e.kind);
                    if (m_read_data !== e.read_data)
                        report_mismatch("read_data", m_read_data, e.read_data);
                    if (m_mmu_slot !== e.slot) report_mismatch("mmu_slot", m_mmu_slot, e.slot);
                    if (m_mmu_page !== e.page) report_mismatch("mmu_page", m_mmu_page, e.page);
                    if (m_last !== e.last) report_mismatch("last", m_last, e.last);
                    if (m_line_irq_enabled !== e.line_en)
                        report_mismatch("line_irq_enabled", m_line_irq_enabled, e.line_en);
                    if (m_ula_irq_disabled !== e.ula_dis)
                        report_mismatch("ula_irq_disabled", m_ula_irq_disabled, e.ula_dis);
                    if (m_line_irq_line !== e.line)
                        report_mismatch("line_irq_line", m_line_irq_line, e.line);
                    if (m_layer2_write_active !== e.l2_active)
                        report_mismatch("layer2_write_active", m_layer2_write_active,
                                        e.l2_active);
                    if (m_layer2_page !== e.l2_page)
                        report_mismatch("layer2_page", m_layer2_page, e.l2_page);
                    if (m_video_shadow !== e.shadow)
                        report_mismatch("video_shadow", m_video_shadow, e.shadow);
                    if (m_rom_select !== e.rom)
                        report_mismatch("rom_select", m_rom_select, e.rom);
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            hold_off <= 0;
        end else if (long_hold_req && hold_off == 0) begin
            hold_off <= 300;
            m_ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else if ($urandom_range(0, 9) < 7) begin
            m_ready <= 1;
        end else begin
            hold_off <= rand_gap();
            m_ready <= 0;
        end
    end

    task automatic add_req(input action_t a, input logic [7:0] r, input logic [7:0] d,
                           input logic [19:0] ts);
        request_t rq;
        rq.action = a;
        rq.reg_index = r;
        rq.data = d;
        rq.tstates = ts;
        pending.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending.size() > 0 || s_valid || expected.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [17:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        if (idx == CFG_TPL) tpl = val[9:0];
        else frame_len = val;
    endtask

    task automatic random_req();
        int r;
        logic [7:0] ri;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) ri = 8'($urandom);
        else case ($urandom_range(0, 9))
            0: ri = REG_LINE_HI;
            1: ri = REG_LINE_LO;
            2: ri = REG_SPEED;
            3: ri = REG_IRQ_CTRL;
            4: ri = REG_IRQ_LINE;
            5: ri = REG_PERIPH3;
            6: ri = $urandom_range(0, 1) ? REG_L2_BANK : REG_L2_SHBNK;
            default: ri = 8'($urandom_range(REG_MMU0, REG_MMU7));
        endcase
        if (r < 30) add_req(ACT_REG_WR, ri, 8'($urandom), 20'($urandom));
        else if (r < 55) add_req(ACT_REG_RD, ri, 8'($urandom), 20'($urandom));
        else if (r < 70) add_req(ACT_PORT_MAIN, 8'($urandom), 8'($urandom), 20'($urandom));
        else if (r < 78) add_req(ACT_PORT_HIGH, 8'($urandom), 8'($urandom), 20'($urandom));
        else if (r < 87) add_req(ACT_PORT_SPECIAL, 8'($urandom), 8'($urandom),
                                 20'($urandom));
        else if (r < 95) add_req(ACT_PORT_L2, 8'($urandom), 8'($urandom), 20'($urandom));
        else if (r < 98) add_req(ACT_SOFT_RST, 8'($urandom), 8'($urandom), 20'($urandom));
        else add_req(ACT_HARD_RST, 8'($urandom), 8'($urandom), 20'($urandom));
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0; s_action = 0; s_reg_index = 0; s_data = 0; s_cpu_tstates = 0;
        m_ready = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        tpl = 228;
        frame_len = 70908;
        restore_defaults(1);
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        add_req(ACT_REG_RD, REG_ID, 8'h00, 20'h0);
        add_req(ACT_REG_RD, REG_VERSION, 8'hFF, 20'h0);
        add_req(ACT_REG_RD, REG_SUBVER, 8'h00, 20'h0);
        add_req(ACT_REG_RD, REG_LINE_LO, 8'h00, 20'hFFFFF);
        add_req(ACT_REG_RD, REG_LINE_HI, 8'h00, 20'd30000);
        add_req(ACT_REG_WR, REG_SPEED, 8'hFF, 20'h0);
        add_req(ACT_REG_RD, REG_SPEED, 8'h00, 20'h0);
        add_req(ACT_REG_RD, REG_LINE_LO, 8'h00, 20'hFFFFF);
        add_req(ACT_REG_WR, REG_IRQ_CTRL, 8'hFF, 20'h0);
        add_req(ACT_REG_WR, REG_IRQ_LINE, 8'hFF, 20'h0);
        add_req(ACT_REG_WR, REG_MMU7, 8'hFF, 20'h0);
        add_req(ACT_PORT_MAIN, 8'h00, 8'h3F, 20'h0);
        add_req(ACT_PORT_MAIN, 8'h00, 8'h10, 20'h0);
        add_req(ACT_REG_WR, REG_PERIPH3, 8'h40, 20'h0);
        add_req(ACT_PORT_MAIN, 8'h00, 8'h07, 20'h0);
        add_req(ACT_PORT_HIGH, 8'h00, 8'hFF, 20'h0);
        add_req(ACT_PORT_HIGH, 8'h00, 8'h0D, 20'h0);
        add_req(ACT_PORT_SPECIAL, 8'h00, 8'h07, 20'h0);
        add_req(ACT_PORT_SPECIAL, 8'h00, 8'h00, 20'h0);
        add_req(ACT_REG_WR, REG_L2_BANK, 8'd110, 20'h0);
        add_req(ACT_PORT_L2, 8'h00, 8'h01, 20'h0);
        add_req(ACT_REG_WR, REG_L2_SHBNK, 8'd8, 20'h0);
        add_req(ACT_PORT_L2, 8'h00, 8'hC9, 20'h0);
        add_req(ACT_SOFT_RST, 8'h00, 8'h00, 20'h0);
        add_req(ACT_HARD_RST, 8'hFF, 8'hFF, 20'hFFFFF);
        wait_drained();

        // random phases over several timing settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_TPL, 18'd1);    write_cfg(CFG_FRAME, 18'h3FFFF); end
                1: begin write_cfg(CFG_TPL, 18'd1023); write_cfg(CFG_FRAME, 18'd1); end
                2: begin write_cfg(CFG_TPL, 18'd1023); write_cfg(CFG_FRAME, 18'h3FFFF); end
                3: begin write_cfg(CFG_TPL, 18'd224);  write_cfg(CFG_FRAME, 18'd70908); end
                4: begin write_cfg(CFG_TPL, 18'($urandom_range(1, 1023)));
                         write_cfg(CFG_FRAME, 18'($urandom_range(1, 262143))); end
                default: begin write_cfg(CFG_TPL, 18'd228); write_cfg(CFG_FRAME, 18'd70908); end
            endcase
            for (int i = 0; i < 68; i++) random_req();
            if (ph == 2) begin
                long_hold_req = 1;
                wait (hold_off > 250);
                long_hold_req = 0;
            end
            wait_drained();
        end
        repeat (200) @(posedge aclk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
